FILE: sv/usbmtx_pkg.sv
`timescale 1ns / 1ps
// usbmtx_pkg: types and constants for the usb-midi transmit packetizer fifo
// no dependencies

package usbmtx_pkg;

  typedef enum logic [1:0] {
    MODE_EVENT = 2'd0,
    MODE_SYSEX = 2'd1,
    MODE_FLUSH = 2'd2,
    MODE_NONE  = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_SHORT = 2'd2
  } status_e;

  typedef enum logic {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  localparam logic [3:0] CIN_SYSEX_BEGIN = 4'h4;
  localparam logic [3:0] CIN_SYSEX_END1  = 4'h5;
  localparam logic [3:0] CIN_SYSEX_END2  = 4'h6;
  localparam logic [3:0] CIN_SYSEX_END3  = 4'h7;

  localparam logic [7:0] SYSEX_EOX = 8'hF7;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned DRAIN_W = 5;
  localparam int unsigned LEN_W   = 7;

  typedef struct packed {
    logic [1:0]        status;
    logic              has_packet;
    logic [WORD_W-1:0] word;
    logic              last;
    logic [LEN_W-1:0]  len;
  } res_t;

endpackage

FILE: sv/usbmtx_ram.sv
`timescale 1ns / 1ps
// usbmtx_ram: generic single-write, single-read ram with registered read data
// no dependencies

module usbmtx_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  input  logic                                  re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/usb_midi_tx_packetizer_fifo_core.sv
`timescale 1ns / 1ps
// usb_midi_tx_packetizer_fifo_core: usb-midi transmit event packet fifo
// depends on usbmtx_pkg and usbmtx_ram
// event, sysex and no-op words each give one registered result in the output queue
// flush: ram read data goes to the output queue, one packet per cycle while it has room
// state returns to idle once the last drained packet is queued; then new words are accepted
// reset clears pointers, held sysex count, flags and cable number; packet ram is not cleared

module usb_midi_tx_packetizer_fifo_core #(
  parameter int unsigned FIFO_DEPTH     = 32,
  parameter int unsigned ENDPOINT_BYTES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] mode_i,
  input  logic [3:0] code_index_i,
  input  logic [7:0] byte0_i,
  input  logic [7:0] byte1_i,
  input  logic [7:0] byte2_i,
  input  logic       sysex_last_i,
  input  logic       endpoint_idle_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic       has_packet_o,
  output logic [7:0] header_o,
  output logic [7:0] data_a_o,
  output logic [7:0] data_b_o,
  output logic [7:0] data_c_o,
  output logic       last_o,
  output logic [6:0] transfer_length_o
);

  localparam int unsigned PTR_W     = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int unsigned DRAIN_MAX = (ENDPOINT_BYTES / 4 < 16) ? ENDPOINT_BYTES / 4 : 16;
  localparam int unsigned DW        = usbmtx_pkg::DRAIN_W;

  usbmtx_pkg::state_e state_q, state_d;
  logic [PTR_W-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [3:0]         cable_q;
  logic [7:0]         held0_q, held0_d, held1_q, held1_d;
  logic [1:0]         held_cnt_q, held_cnt_d;
  logic               discard_q, discard_d;
  logic               in_msg_q, in_msg_d;
  logic [DW-1:0]      rem_q, rem_d, total_q, total_d;
  logic               rdv_q, rdv_d, rd_last_q, rd_last_d;

  usbmtx_pkg::res_t   q_ent_q [2];
  logic               q_head_q;
  logic [1:0]         q_cnt_q;
  usbmtx_pkg::res_t   res_in;
  usbmtx_pkg::res_t   head;
  logic               res_push, pop;

  logic               in_acc;
  logic               push_req, full, mem_we, rd_issue;
  logic [3:0]         push_code;
  logic [7:0]         push_a, push_b, push_c;
  logic [PTR_W-1:0]   wp_next, rp_next;
  logic [PTR_W:0]     occ;
  logic [DW-1:0]      drain_n;
  logic [2:0]         credit;
  logic [1:0]         st;
  logic [usbmtx_pkg::WORD_W-1:0] rdata, wdata;

  assign wp_next = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
  assign rp_next = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;
  assign full    = (wp_next == rp_q);
  assign mem_we  = push_req && !full;
  assign wdata   = {push_c, push_b, push_a, cable_q, push_code};

  assign occ     = {1'b0, wp_q} - {1'b0, rp_q}
                   + ((wp_q < rp_q) ? (PTR_W + 1)'(FIFO_DEPTH) : '0);
  assign drain_n = (32'(occ) < DRAIN_MAX) ? DW'(occ) : DW'(DRAIN_MAX);

  assign in_stall_o = !(state_q == usbmtx_pkg::ST_IDLE && q_cnt_q != 2'd2);
  assign in_acc     = in_valid_i && !in_stall_o;

  assign head        = q_ent_q[q_head_q];
  assign out_valid_o = (q_cnt_q != 2'd0);
  assign pop         = out_valid_o && !out_stall_i;
  assign credit      = 3'(q_cnt_q) + 3'(rdv_q) - 3'(pop);

  usbmtx_ram #(
    .WIDTH (usbmtx_pkg::WORD_W),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wp_q),
    .wdata_i (wdata),
    .re_i    (rd_issue),
    .raddr_i (rp_q),
    .rdata_o (rdata)
  );

  always_comb begin
    state_d    = state_q;
    wp_d       = mem_we ? wp_next : wp_q;
    rp_d       = rp_q;
    held0_d    = held0_q;
    held1_d    = held1_q;
    held_cnt_d = held_cnt_q;
    discard_d  = discard_q;
    in_msg_d   = in_msg_q;
    rem_d      = rem_q;
    total_d    = total_q;
    rdv_d      = 1'b0;
    rd_last_d  = rd_last_q;
    rd_issue   = 1'b0;
    push_req   = 1'b0;
    push_code  = code_index_i;
    push_a     = byte0_i;
    push_b     = byte1_i;
    push_c     = byte2_i;
    st         = usbmtx_pkg::STAT_OK;
    res_push   = 1'b0;
    res_in     = '0;

    unique case (state_q)
      usbmtx_pkg::ST_IDLE: begin
        if (in_acc) begin
          res_push = 1'b1;
          case (mode_i)
            usbmtx_pkg::MODE_EVENT: begin
              push_req = 1'b1;
              st       = full ? usbmtx_pkg::STAT_FULL : usbmtx_pkg::STAT_OK;
            end
            usbmtx_pkg::MODE_SYSEX: begin
              push_a = held0_q;
              push_b = held1_q;
              push_c = byte0_i;
              if (discard_q) begin
                st = usbmtx_pkg::STAT_FULL;
                if (sysex_last_i) begin
                  discard_d  = 1'b0;
                  held_cnt_d = 2'd0;
                  in_msg_d   = 1'b0;
                end
              end else if (sysex_last_i) begin
                held_cnt_d = 2'd0;
                in_msg_d   = 1'b0;
                if (held_cnt_q == 2'd0 && !in_msg_q) begin
                  st = usbmtx_pkg::STAT_SHORT;
                end else begin
                  push_req = 1'b1;
                  st       = full ? usbmtx_pkg::STAT_FULL : usbmtx_pkg::STAT_OK;
                  if (held_cnt_q[1]) begin
                    push_code = (byte0_i == usbmtx_pkg::SYSEX_EOX) ?
                                usbmtx_pkg::CIN_SYSEX_END3 : usbmtx_pkg::CIN_SYSEX_BEGIN;
                  end else if (held_cnt_q == 2'd1) begin
                    push_code = usbmtx_pkg::CIN_SYSEX_END2;
                    push_b    = byte0_i;
                    push_c    = 8'd0;
                  end else begin
                    push_code = usbmtx_pkg::CIN_SYSEX_END1;
                    push_a    = byte0_i;
                    push_b    = 8'd0;
                    push_c    = 8'd0;
                  end
                end
              end else if (held_cnt_q[1]) begin
                held_cnt_d = 2'd0;
                push_req   = 1'b1;
                push_code  = usbmtx_pkg::CIN_SYSEX_BEGIN;
                if (full) begin
                  discard_d = 1'b1;
                  in_msg_d  = 1'b0;
                  st        = usbmtx_pkg::STAT_FULL;
                end else begin
                  in_msg_d = 1'b1;
                end
              end else begin
                if (held_cnt_q == 2'd0) begin
                  held0_d = byte0_i;
                end else begin
                  held1_d = byte0_i;
                end
                held_cnt_d = held_cnt_q + 2'd1;
                in_msg_d   = 1'b1;
              end
            end
            usbmtx_pkg::MODE_FLUSH: begin
              if (endpoint_idle_i && wp_q != rp_q) begin
                res_push = 1'b0;
                state_d  = usbmtx_pkg::ST_DRAIN;
                rem_d    = drain_n;
                total_d  = drain_n;
              end
            end
            default: ;
          endcase
          res_in.status = st;
          res_in.last   = 1'b1;
        end
      end
      usbmtx_pkg::ST_DRAIN: begin
        // read only when the output queue has room for the returning word
        if (rem_q != '0 && credit < 3'd2) begin
          rd_issue  = 1'b1;
          rdv_d     = 1'b1;
          rd_last_d = (rem_q == DW'(1));
          rem_d     = rem_q - 1'b1;
          rp_d      = rp_next;
        end
        if (rdv_q) begin
          res_push          = 1'b1;
          res_in.status     = usbmtx_pkg::STAT_OK;
          res_in.has_packet = 1'b1;
          res_in.word       = rdata;
          res_in.last       = rd_last_q;
          res_in.len        = rd_last_q ? {total_q, 2'b00} : '0;
          if (rd_last_q) begin
            state_d = usbmtx_pkg::ST_IDLE;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= usbmtx_pkg::ST_IDLE;
      wp_q       <= '0;
      rp_q       <= '0;
      cable_q    <= '0;
      held_cnt_q <= '0;
      discard_q  <= 1'b0;
      in_msg_q   <= 1'b0;
      rem_q      <= '0;
      rdv_q      <= 1'b0;
      rd_last_q  <= 1'b0;
      q_head_q   <= 1'b0;
      q_cnt_q    <= '0;
    end else begin
      state_q    <= state_d;
      wp_q       <= wp_d;
      rp_q       <= rp_d;
      held_cnt_q <= held_cnt_d;
      discard_q  <= discard_d;
      in_msg_q   <= in_msg_d;
      rem_q      <= rem_d;
      rdv_q      <= rdv_d;
      rd_last_q  <= rd_last_d;
      q_head_q   <= q_head_q ^ pop;
      q_cnt_q    <= q_cnt_q + 2'(res_push) - 2'(pop);
      if (cfg_we_i) begin
        cable_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    held0_q <= held0_d;
    held1_q <= held1_d;
    total_q <= total_d;
    if (res_push) begin
      q_ent_q[q_head_q ^ q_cnt_q[0]] <= res_in;
    end
  end

  assign status_o          = head.status;
  assign has_packet_o      = head.has_packet;
  assign header_o          = head.word[7:0];
  assign data_a_o          = head.word[15:8];
  assign data_b_o          = head.word[23:16];
  assign data_c_o          = head.word[31:24];
  assign last_o            = head.last;
  assign transfer_length_o = head.len;

  a_queue_credit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (3'(q_cnt_q) + 3'(rdv_q)) <= 3'd2)
    else $error("output queue overcommitted");

  a_accept_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> !rdv_q && rem_q == '0)
    else $error("word accepted while a drain is in progress");

  a_read_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_issue |-> wp_q != rp_q)
    else $error("drain read from an empty fifo");

  a_drain_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && has_packet_o && last_o |-> transfer_length_o != '0)
    else $error("last drained packet without a transfer length");

  a_no_write_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == usbmtx_pkg::ST_DRAIN |-> !mem_we && $stable(wp_q))
    else $error("packet written during a drain");

endmodule
